[hw/rtl/l2s_pkg.sv]
// shared constants, types and table builders for the srgb encoder
package l2s_pkg;

    localparam int FRACTION_BITS     = 16;
    localparam int POW_TABLE_ENTRIES = 256;
    localparam int TAB_SHIFT         = $clog2(POW_TABLE_ENTRIES);

    localparam int LOG_W = FRACTION_BITS + 1;
    localparam int EXP_W = FRACTION_BITS + 2;
    localparam int LN_W  = FRACTION_BITS + 5;
    localparam int YN_W  = FRACTION_BITS + 9;
    localparam int K_W   = YN_W - FRACTION_BITS + 1;

    localparam int LANE_DEPTH = 9;

    localparam logic [7:0]  LIN_THRESHOLD = 8'd205;
    localparam logic [19:0] LIN_SLOPE     = 20'd846725;
    localparam logic [16:0] ENC_SCALE     = 17'd69140;
    localparam logic [11:0] ENC_OFFSET    = 12'd3604;
    localparam logic [15:0] GAMMA_RESET   = 16'd1707;

    typedef logic [LOG_W-1:0] log_tab_t [POW_TABLE_ENTRIES+1];
    typedef logic [EXP_W-1:0] exp_tab_t [POW_TABLE_ENTRIES+1];

    function automatic longint unsigned isqrt64(input longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bitv;
        v    = v_in;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic log_tab_t make_log_table();
        log_tab_t        tab;
        longint unsigned one30;
        longint unsigned x;
        longint unsigned bits;
        one30 = 64'd1 << 30;
        for (int i = 0; i <= POW_TABLE_ENTRIES; i++) begin
            x    = ((longint'(POW_TABLE_ENTRIES) + longint'(i)) << 30) / POW_TABLE_ENTRIES;
            bits = 0;
            if (x >= 2 * one30) begin
                tab[i] = LOG_W'(64'd1 << FRACTION_BITS);
            end else begin
                for (int b = 0; b < FRACTION_BITS + 1; b++) begin
                    x    = (x * x) >> 30;
                    bits = bits << 1;
                    if (x >= 2 * one30) begin
                        bits = bits | 64'd1;
                        x    = x >> 1;
                    end
                end
                tab[i] = LOG_W'((bits + 1) >> 1);
            end
        end
        return tab;
    endfunction

    function automatic exp_tab_t make_exp_table();
        exp_tab_t        tab;
        longint unsigned one30;
        longint unsigned roots [31];
        longint unsigned f;
        longint unsigned e;
        one30    = 64'd1 << 30;
        roots[0] = 2 * one30;
        for (int b = 1; b <= 30; b++)
            roots[b] = isqrt64(roots[b-1] << 30);
        for (int i = 0; i <= POW_TABLE_ENTRIES; i++) begin
            if (i >= POW_TABLE_ENTRIES) begin
                tab[i] = EXP_W'(64'd2 << FRACTION_BITS);
            end else begin
                f = (longint'(i) << 30) / POW_TABLE_ENTRIES;
                e = one30;
                for (int b = 1; b <= 30; b++)
                    if (((f >> (30 - b)) & 64'd1) != 0)
                        e = (e * roots[b] + (one30 >> 1)) >> 30;
                tab[i] = EXP_W'((e + (64'd1 << (29 - FRACTION_BITS)))
                                >> (30 - FRACTION_BITS));
            end
        end
        return tab;
    endfunction

    localparam log_tab_t LOG_TABLE = make_log_table();
    localparam exp_tab_t EXP_TABLE = make_exp_table();

endpackage

[hw/rtl/linear_to_srgb_gamma_encode.sv]
// top level: three channel lanes, alpha delay line and output beat merge
// an accepted input beat passes through every lane stage register and the alpha delay line to its output beat
// throughput: one pixel per cycle while no output beat is stalled; every lane pipeline stage is one register
// an output beat held by m_tready low freezes the whole pipeline, s_tready follows it
// reset clears all beat valid flags and loads the exponent with 1707
// no clearing pass: the log2 and exp2 tables are constant logic
module linear_to_srgb_gamma_encode (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // red_linear[17:0], green_linear[35:18], blue_linear[53:36], alpha_in[69:54]
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // red_srgb[15:0], green_srgb[31:16], blue_srgb[47:32], alpha_out[63:48]
    output logic [63:0] m_tdata
);

    localparam int D = l2s_pkg::LANE_DEPTH;

    logic [15:0]  gamma_reg;
    logic [D-1:0] vld_reg;
    logic [15:0]  alpha_reg [D];
    logic         en;
    logic [15:0]  red_o;
    logic [15:0]  green_o;
    logic [15:0]  blue_o;

    assign en       = !vld_reg[D-1] || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gamma_reg <= l2s_pkg::GAMMA_RESET;
        end else if (cfg_we) begin
            gamma_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[D-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            alpha_reg[0] <= s_tdata[69:54];
            for (int i = 1; i < D; i++)
                alpha_reg[i] <= alpha_reg[i-1];
        end
    end

    l2s_lane u_red (
        .aclk     (aclk),
        .en       (en),
        .gamma    (gamma_reg),
        .chan_in  (s_tdata[17:0]),
        .chan_out (red_o)
    );

    l2s_lane u_green (
        .aclk     (aclk),
        .en       (en),
        .gamma    (gamma_reg),
        .chan_in  (s_tdata[35:18]),
        .chan_out (green_o)
    );

    l2s_lane u_blue (
        .aclk     (aclk),
        .en       (en),
        .gamma    (gamma_reg),
        .chan_in  (s_tdata[53:36]),
        .chan_out (blue_o)
    );

    assign m_tvalid = vld_reg[D-1];
    assign m_tdata  = {alpha_reg[D-1], blue_o, green_o, red_o};

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output beat valid right after reset");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output beat stalled");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted beat missing from pipeline");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule

[hw/rtl/l2s_lane.sv]
// one colour channel encode pipeline: clamp, log2, scale, exp2, final affine, or the linear branch bypass
module l2s_lane (
    input  logic        aclk,
    input  logic        en,
    input  logic [15:0] gamma,
    input  logic [17:0] chan_in,
    output logic [15:0] chan_out
);

    localparam int F  = l2s_pkg::FRACTION_BITS;
    localparam int TS = l2s_pkg::TAB_SHIFT;
    localparam int LW = l2s_pkg::LOG_W;
    localparam int EW = l2s_pkg::EXP_W;
    localparam int NW = l2s_pkg::LN_W;
    localparam int YW = l2s_pkg::YN_W;
    localparam int KW = l2s_pkg::K_W;

    // stage 1: clamp, linear branch, normalize
    logic [16:0]    c;
    logic           is_lin;
    logic [28:0]    lin_prod;
    logic [4:0]     p;
    logic [16:0]    norm;
    logic [15:0]    m;
    logic [31:0]    m_sh;

    logic           pw1_reg;
    logic [15:0]    byp1_reg;
    logic [TS-1:0]  j1_reg;
    logic [15:0]    r1_reg;
    logic [4:0]     sh1_reg;

    always_comb begin
        c        = (chan_in[16:0] > 17'd65536) ? 17'd65536 : chan_in[16:0];
        is_lin   = (c < {9'd0, l2s_pkg::LIN_THRESHOLD});
        lin_prod = 29'(c[7:0]) * 29'(l2s_pkg::LIN_SLOPE) + 29'd32768;
        p        = 5'd0;
        for (int i = 0; i < 17; i++)
            if (c[i])
                p = 5'(i);
        norm     = c << (5'd16 - p);
        m        = norm[15:0];
        m_sh     = {16'd0, m} << TS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pw1_reg  <= !chan_in[17] && !is_lin;
            byp1_reg <= (!chan_in[17] && is_lin) ? {3'd0, lin_prod[28:16]} : 16'd0;
            j1_reg   <= m[15 -: TS];
            r1_reg   <= m_sh[15:0];
            sh1_reg  <= 5'd16 - p;
        end
    end

    // stage 2: log table read
    logic           pw2_reg;
    logic [15:0]    byp2_reg;
    logic [15:0]    r2_reg;
    logic [4:0]     sh2_reg;
    logic [LW-1:0]  la_reg;
    logic [LW-1:0]  lb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pw2_reg  <= pw1_reg;
            byp2_reg <= byp1_reg;
            r2_reg   <= r1_reg;
            sh2_reg  <= sh1_reg;
            la_reg   <= l2s_pkg::LOG_TABLE[{1'b0, j1_reg}];
            lb_reg   <= l2s_pkg::LOG_TABLE[{1'b0, j1_reg} + (TS+1)'(1)];
        end
    end

    // stage 3: log interpolation
    logic [LW-1:0]  ld;
    logic [LW+16:0] frac_sum;
    logic [LW-1:0]  frac;
    logic [NW-1:0]  ln;

    logic           pw3_reg;
    logic [15:0]    byp3_reg;
    logic [NW-1:0]  ln3_reg;

    always_comb begin
        ld       = lb_reg - la_reg;
        frac_sum = ({1'b0, la_reg, 16'd0}) + (LW+17)'(ld) * (LW+17)'(r2_reg)
                   + (LW+17)'(32768);
        frac     = frac_sum[LW+15:16];
        ln       = (NW'(sh2_reg) << F) - NW'(frac);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pw3_reg  <= pw2_reg;
            byp3_reg <= byp2_reg;
            ln3_reg  <= ln;
        end
    end

    // stage 4: scale by exponent
    logic [NW+16:0] yprod;

    logic           pw4_reg;
    logic [15:0]    byp4_reg;
    logic [YW-1:0]  yn4_reg;

    always_comb begin
        yprod = (NW+17)'(ln3_reg) * (NW+17)'(gamma) + (NW+17)'(2048);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pw4_reg  <= pw3_reg;
            byp4_reg <= byp3_reg;
            yn4_reg  <= yprod[YW+11:12];
        end
    end

    // stage 5: split into integer and fraction
    logic [YW:0]    ysum;
    logic [KW-1:0]  k;
    logic [F-1:0]   f;
    logic [F+TS-1:0] f_sh;

    logic           pw5_reg;
    logic [15:0]    byp5_reg;
    logic [KW-1:0]  k5_reg;
    logic [TS-1:0]  j5_reg;
    logic [F-1:0]   r5_reg;

    always_comb begin
        ysum = {1'b0, yn4_reg} + (YW+1)'((1 << F) - 1);
        k    = ysum[YW:F];
        f    = F'(((YW+1)'(k) << F) - (YW+1)'(yn4_reg));
        f_sh = (F+TS)'(f) << TS;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pw5_reg  <= pw4_reg;
            byp5_reg <= byp4_reg;
            k5_reg   <= k;
            j5_reg   <= f[F-1 -: TS];
            r5_reg   <= f_sh[F-1:0];
        end
    end

    // stage 6: exp table read
    logic           pw6_reg;
    logic [15:0]    byp6_reg;
    logic [KW-1:0]  k6_reg;
    logic [F-1:0]   r6_reg;
    logic [EW-1:0]  ea_reg;
    logic [EW-1:0]  eb_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pw6_reg  <= pw5_reg;
            byp6_reg <= byp5_reg;
            k6_reg   <= k5_reg;
            r6_reg   <= r5_reg;
            ea_reg   <= l2s_pkg::EXP_TABLE[{1'b0, j5_reg}];
            eb_reg   <= l2s_pkg::EXP_TABLE[{1'b0, j5_reg} + (TS+1)'(1)];
        end
    end

    // stage 7: exp interpolation
    logic [EW-1:0]  ed;
    logic [EW+F:0]  e_sum;

    logic           pw7_reg;
    logic [15:0]    byp7_reg;
    logic [KW-1:0]  k7_reg;
    logic [EW-1:0]  e7_reg;

    always_comb begin
        ed    = eb_reg - ea_reg;
        e_sum = ({1'b0, ea_reg, F'(0)}) + (EW+F+1)'(ed) * (EW+F+1)'(r6_reg)
                + (EW+F+1)'(1 << (F - 1));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pw7_reg  <= pw6_reg;
            byp7_reg <= byp6_reg;
            k7_reg   <= k6_reg;
            e7_reg   <= e_sum[EW+F-1:F];
        end
    end

    // stage 8: rounded right shift by k
    logic [EW:0]    q_sum;
    logic [EW:0]    q_sh;
    logic [EW-1:0]  q;

    logic           pw8_reg;
    logic [15:0]    byp8_reg;
    logic [EW-1:0]  q8_reg;

    always_comb begin
        q_sum = {1'b0, e7_reg} + ((EW+1)'(1) << (k7_reg - KW'(1)));
        q_sh  = q_sum >> k7_reg;
        if (k7_reg == KW'(0))
            q = e7_reg;
        else if (k7_reg > KW'(F + 2))
            q = EW'(0);
        else
            q = q_sh[EW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pw8_reg  <= pw7_reg;
            byp8_reg <= byp7_reg;
            q8_reg   <= q;
        end
    end

    // stage 9: affine and saturate
    logic [EW+17:0] num;
    logic [EW+17:0] sub;
    logic [EW+17:0] diff;
    logic [15:0]    pow_out;
    logic [15:0]    out_reg;

    always_comb begin
        num  = (EW+18)'(q8_reg) * (EW+18)'(l2s_pkg::ENC_SCALE) + (EW+18)'(1 << (F - 1));
        sub  = (EW+18)'(l2s_pkg::ENC_OFFSET) << F;
        diff = (num - sub) >> F;
        if (num <= sub)
            pow_out = 16'd0;
        else if (diff > (EW+18)'(65535))
            pow_out = 16'hFFFF;
        else
            pow_out = diff[15:0];
    end

    always_ff @(posedge aclk) begin
        if (en)
            out_reg <= pw8_reg ? pow_out : byp8_reg;
    end

    assign chan_out = out_reg;

endmodule

[tb/sv/srgb_encode_checker.sv]
// checker for the srgb encoder: predicts each pixel from input beats and compares output beats
module srgb_encode_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    output int          fail_count,
    output int          pixels_waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] alpha;
        logic [15:0] blue;
        logic [15:0] green;
        logic [15:0] red;
    } srgb_pixel_t;

    longint unsigned log2_rom [l2s_pkg::POW_TABLE_ENTRIES+1];
    longint unsigned exp2_rom [l2s_pkg::POW_TABLE_ENTRIES+1];
    logic [15:0]     gamma_q412;
    srgb_pixel_t     encoded_q [$];

    function automatic longint unsigned floor_root(input longint unsigned v);
        longint unsigned acc;
        longint unsigned trial;
        acc = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = acc | (64'd1 << b);
            if (trial * trial <= v)
                acc = trial;
        end
        return acc;
    endfunction

    task automatic fill_tables();
        longint unsigned unit30;
        longint unsigned sq [31];
        longint unsigned x;
        longint unsigned acc;
        longint unsigned fr;
        longint unsigned pw;
        unit30 = 64'd1 << 30;
        sq[0] = 2 * unit30;
        for (int b = 1; b <= 30; b++)
            sq[b] = floor_root(sq[b-1] << 30);
        for (int i = 0; i <= l2s_pkg::POW_TABLE_ENTRIES; i++) begin
            x = ((l2s_pkg::POW_TABLE_ENTRIES + i) * unit30) / l2s_pkg::POW_TABLE_ENTRIES;
            acc = 0;
            if (x >= 2 * unit30) begin
                log2_rom[i] = 64'd1 << l2s_pkg::FRACTION_BITS;
            end else begin
                for (int b = 0; b <= l2s_pkg::FRACTION_BITS; b++) begin
                    x = (x * x) >> 30;
                    acc = acc << 1;
                    if (x >= 2 * unit30) begin
                        acc = acc + 1;
                        x = x >> 1;
                    end
                end
                log2_rom[i] = (acc + 1) >> 1;
            end
            if (i == l2s_pkg::POW_TABLE_ENTRIES) begin
                exp2_rom[i] = 64'd2 << l2s_pkg::FRACTION_BITS;
            end else begin
                fr = (longint'(i) << 30) / l2s_pkg::POW_TABLE_ENTRIES;
                pw = unit30;
                for (int b = 1; b <= 30; b++)
                    if (fr[30-b])
                        pw = (pw * sq[b] + (unit30 >> 1)) >> 30;
                exp2_rom[i] = (pw + (64'd1 << (29 - l2s_pkg::FRACTION_BITS)))
                              >> (30 - l2s_pkg::FRACTION_BITS);
            end
        end
    endtask

    function automatic logic [15:0] encode_lane(input logic [17:0] lin, input logic [15:0] g);
        longint unsigned one_f;
        longint unsigned c;
        longint unsigned mant;
        longint unsigned t;
        longint unsigned j;
        longint unsigned r;
        longint unsigned lfrac;
        longint unsigned lmag;
        longint unsigned ymag;
        longint unsigned k;
        longint unsigned fpart;
        longint unsigned e;
        longint unsigned q;
        longint unsigned num;
        longint unsigned sub;
        int              msb;
        one_f = 64'd1 << l2s_pkg::FRACTION_BITS;
        if (lin[17])
            return 16'd0;
        c = (lin > 18'd65536) ? 64'd65536 : longint'(lin);
        if (c < l2s_pkg::LIN_THRESHOLD)
            return 16'((c * l2s_pkg::LIN_SLOPE + 32768) >> 16);
        msb = 16;
        while (msb > 0 && c[msb] == 1'b0)
            msb--;
        mant = (c << (16 - msb)) - 65536;
        t = mant * l2s_pkg::POW_TABLE_ENTRIES;
        j = t >> 16;
        r = t & 64'hFFFF;
        lfrac = (log2_rom[j] * (65536 - r) + log2_rom[j+1] * r + 32768) >> 16;
        lmag = (longint'(16 - msb) << l2s_pkg::FRACTION_BITS) - lfrac;
        ymag = (lmag * g + 2048) >> 12;
        k = (ymag + one_f - 1) >> l2s_pkg::FRACTION_BITS;
        fpart = (k << l2s_pkg::FRACTION_BITS) - ymag;
        t = fpart * l2s_pkg::POW_TABLE_ENTRIES;
        j = t >> l2s_pkg::FRACTION_BITS;
        r = t & (one_f - 1);
        e = (exp2_rom[j] * (one_f - r) + exp2_rom[j+1] * r + (one_f >> 1))
            >> l2s_pkg::FRACTION_BITS;
        if (k == 0)
            q = e;
        else if (k <= 40)
            q = (e + (64'd1 << (k - 1))) >> k;
        else
            q = 0;
        num = q * l2s_pkg::ENC_SCALE + (one_f >> 1);
        sub = longint'(l2s_pkg::ENC_OFFSET) << l2s_pkg::FRACTION_BITS;
        if (num <= sub)
            return 16'd0;
        num = (num - sub) >> l2s_pkg::FRACTION_BITS;
        return (num > 65535) ? 16'hFFFF : 16'(num);
    endfunction

    initial begin
        fail_count = 0;
        fill_tables();
    end

    assign pixels_waiting = encoded_q.size();

    always @(posedge aclk) begin
        srgb_pixel_t want;
        srgb_pixel_t got;
        if (!aresetn) begin
            gamma_q412 <= l2s_pkg::GAMMA_RESET;
        end else begin
            if (cfg_we)
                gamma_q412 <= cfg_wdata;
            if (s_tvalid && s_tready) begin
                want.red   = encode_lane(s_tdata[17:0], gamma_q412);
                want.green = encode_lane(s_tdata[35:18], gamma_q412);
                want.blue  = encode_lane(s_tdata[53:36], gamma_q412);
                want.alpha = s_tdata[69:54];
                encoded_q.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (encoded_q.size() == 0) begin
                    $display("%0t: unexpected output beat %h", $realtime, got);
                    fail_count++;
                end else begin
                    want = encoded_q.pop_front();
                    if (got.red !== want.red) begin
                        $display("%0t: red expected %h got %h", $realtime, want.red, got.red);
                        fail_count++;
                    end
                    if (got.green !== want.green) begin
                        $display("%0t: green expected %h got %h", $realtime, want.green,
                                 got.green);
                        fail_count++;
                    end
                    if (got.blue !== want.blue) begin
                        $display("%0t: blue expected %h got %h", $realtime, want.blue, got.blue);
                        fail_count++;
                    end
                    if (got.alpha !== want.alpha) begin
                        $display("%0t: alpha expected %h got %h", $realtime, want.alpha,
                                 got.alpha);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

[tb/sv/linear_to_srgb_gamma_encode_test.sv]
// testbench top for the srgb encoder: clock, reset, stimulus, stalls and verdict
module linear_to_srgb_gamma_encode_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 20;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    int          fail_count;
    int          pixels_waiting;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_requests;
    int          holds_served;
    int          quiet_cycles;
    int          pixels_sent;
    int          settings_used;

    linear_to_srgb_gamma_encode uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    srgb_encode_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pixels_waiting(pixels_waiting)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver side: random stalls plus long hold-offs on request
    initial begin
        m_tready = 1'b0;
        holds_served = 0;
        forever begin
            @(posedge aclk);
            if (hold_requests != holds_served) begin
                holds_served++;
                m_tready <= 1'b0;
                repeat (80) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("linear_to_srgb_gamma_encode verification failed");
            $finish;
        end
    end

    task automatic send_pixel(input logic [17:0] r, input logic [17:0] g, input logic [17:0] b,
                              input logic [15:0] a);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, a, b, g, r};
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
    endtask

    function automatic logic [17:0] pick_lane();
        case ($urandom_range(9))
            0:       return 18'($urandom);
            1:       return 18'($urandom_range(260));
            2:       return 18'($urandom_range(65536) | 18'h20000);
            3:       return 18'($urandom_range(131071, 65530));
            default: return 18'($urandom_range(65536));
        endcase
    endfunction

    task automatic settle_and_write(input logic [15:0] g);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pixels_waiting == 0);
        repeat (12) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= g;
        @(posedge aclk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic random_run(input int count, input int idle, input int stall);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++)
            send_pixel(pick_lane(), pick_lane(), pick_lane(), 16'($urandom));
    endtask

    initial begin
        logic [15:0] gammas [6];
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests = 0;
        quiet_cycles = 0;
        pixels_sent = 0;
        settings_used = 1;
        gammas = '{16'd0, 16'd65535, 16'd4096, 16'd1707, 16'd1, 16'($urandom_range(1000, 12000))};
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed pass at the reset exponent, then at zero, full scale and 4096
        send_pixel(18'h20000, 18'h3FFFF, 18'd0, 16'h0000);
        send_pixel(18'h1FFFF, 18'd65536, 18'd65535, 16'hFFFF);
        send_pixel(18'd204, 18'd205, 18'd206, 16'h5A5A);
        send_pixel(18'd1, 18'd2, 18'd128, 16'hA5A5);
        send_pixel(18'd65537, 18'd32768, 18'd256, 16'h0001);
        send_pixel(18'd512, 18'd1024, 18'd16384, 16'h8000);
        settle_and_write(16'd0);
        send_pixel(18'd205, 18'd204, 18'd65536, 16'h1234);
        send_pixel(18'd300, 18'h30000, 18'd40000, 16'h4321);
        settle_and_write(16'd65535);
        send_pixel(18'd205, 18'd1000, 18'd65535, 16'h7FFF);
        send_pixel(18'd65536, 18'd30000, 18'd206, 16'hFFFE);
        settle_and_write(16'd4096);
        send_pixel(18'd205, 18'd3000, 18'd65536, 16'h00FF);

        // long receiver hold while the sender keeps offering
        settle_and_write(16'd1707);
        recv_stall_pct = 0;
        hold_requests++;
        random_run(40, 0, 0);

        for (int ph = 0; ph < 6; ph++) begin
            settle_and_write(gammas[ph]);
            random_run(15, 0, 0);
            random_run(15, 56, 0);
            random_run(15, 0, 56);
            random_run(15, 8, 8);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait (pixels_waiting == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("pixels sent: %0d across %0d exponent settings incl. zero and full scale",
                 pixels_sent, settings_used);
        $display("covered clamps, threshold edges, alpha extremes, stalls and a long hold");
        if (fail_count == 0)
            $display("linear_to_srgb_gamma_encode verification clean");
        else
            $display("linear_to_srgb_gamma_encode verification failed");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/l2s_pkg.sv
hw/rtl/l2s_lane.sv
hw/rtl/linear_to_srgb_gamma_encode.sv
tb/sv/srgb_encode_checker.sv
tb/sv/linear_to_srgb_gamma_encode_test.sv
